### rtl/tpmh_pkg.sv
package tpmh_pkg;

  localparam int WW = 50;

  localparam logic [WW-1:0] WATER_MASS   = 50'd1801056;
  localparam logic [WW-1:0] PROTON_MASS  = 50'd100728;
  localparam logic [WW-1:0] PEPTIDE_BIN  = 50'd10000000;
  localparam logic [WW-1:0] PROTEIN_BIN  = 50'd1000000000;
  localparam logic [24:0]   CARBAMIDOMETHYL = 25'd5702146;

  // Each bin is a power of two times an odd factor. The quotient by the odd
  // factor comes from a reciprocal estimate and one correction step.
  localparam int          PEP_BIN_SHIFT   = 7;
  localparam logic [20:0] PEP_BIN_ODD     = 21'd78125;
  localparam logic [8:0]  PEP_RECIP       = 9'd429;
  localparam int          PEP_RECIP_SHIFT = 25;
  localparam int          COL_BIN_SHIFT   = 9;
  localparam logic [20:0] COL_BIN_ODD     = 21'd1953125;
  localparam logic [8:0]  COL_RECIP       = 9'd274;
  localparam int          COL_RECIP_SHIFT = 29;

  localparam logic [39:0] MASS40_MAX = {40{1'b1}};
  localparam logic [47:0] MASS48_MAX = {48{1'b1}};

  localparam logic [1:0] REQ_RESIDUE = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_UNUSED  = 2'd3;

  localparam logic [7:0] CHAR_P = "P";
  localparam logic [7:0] CHAR_K = "K";
  localparam logic [7:0] CHAR_R = "R";

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_CLEAR,
    S_CLOSE,
    S_PEP_LOAD,
    S_COL_LOAD,
    S_DIV,
    S_TALLY_RD,
    S_TALLY_WR,
    S_ADD,
    S_MERGE_RD,
    S_MERGE_WR
  } state_t;

  typedef struct packed {
    logic [24:0] mass;
    logic        bad;
  } letter_t;

  function automatic letter_t letter_mass(input logic [7:0] c);
    letter_t r;
    r.bad = 1'b0;
    case (c)
      "A": r.mass = 25'd7103711;
      "R": r.mass = 25'd15610111;
      "N": r.mass = 25'd11404293;
      "D": r.mass = 25'd11502694;
      "C": r.mass = 25'd10300919 + CARBAMIDOMETHYL;
      "E": r.mass = 25'd12904259;
      "Q": r.mass = 25'd12805858;
      "G": r.mass = 25'd5702146;
      "H": r.mass = 25'd13705891;
      "I": r.mass = 25'd11308406;
      "L": r.mass = 25'd11308406;
      "K": r.mass = 25'd12809496;
      "M": r.mass = 25'd13104049;
      "F": r.mass = 25'd14706841;
      "P": r.mass = 25'd9705276;
      "S": r.mass = 25'd8703203;
      "T": r.mass = 25'd10104768;
      "W": r.mass = 25'd18607931;
      "Y": r.mass = 25'd16306333;
      "V": r.mass = 25'd9906841;
      default: begin
        r.mass = 25'd0;
        r.bad  = 1'b1;
      end
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### rtl/tpmh_ram.sv
module tpmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tryptic_peptide_mass_histogram.sv
// Channel  | Direction | Signals
// command  | in/out    | start, busy (out), req_type, residue, protein_end, row, column
// result   | out       | result_valid, cell_count, column_peak
// config   | in/out    | cfg_valid, cfg_ready (out), cfg_data
// A residue passes S_ADD; one that closes a peptide first passes S_CLOSE, then per
// counted peptide S_PEP_LOAD, the two-step quotient in S_DIV (skipped when the row
// clamps), S_TALLY_RD and S_TALLY_WR. A protein end adds that close, then
// S_COL_LOAD, S_DIV (skipped when the column clamps) and S_MERGE_RD and S_MERGE_WR
// for each mass row. A read passes S_READ; a clear writes every matrix cell. After
// reset the block is busy while it clears its memories. The receiver cannot stall:
// each result word is shown for one cycle.
module tryptic_peptide_mass_histogram
  import tpmh_pkg::*;
#(
  parameter int MASS_ROWS       = 40,
  parameter int PROTEIN_COLUMNS = 30,
  parameter int MAX_MISSED      = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [7:0]  residue,
  input  logic        protein_end,
  input  logic [5:0]  row,
  input  logic [4:0]  column,
  output logic        result_valid,
  output logic [31:0] cell_count,
  output logic [31:0] column_peak,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  localparam int DEPTH = MASS_ROWS * PROTEIN_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MASS_ROWS);
  localparam int CW    = $clog2(PROTEIN_COLUMNS);
  localparam int JW    = $clog2(MAX_MISSED + 1);
  localparam int RI    = (MAX_MISSED > 1) ? $clog2(MAX_MISSED) : 1;
  localparam logic [WW-1:0] PEP_LIMIT = WW'(64'(MASS_ROWS) * 64'(PEPTIDE_BIN));
  localparam logic [WW-1:0] COL_LIMIT = WW'(64'(PROTEIN_COLUMNS) * 64'(PROTEIN_BIN));

  state_t state, state_next;

  logic [2:0]      missed_cleavages;
  logic [39:0]     open_mass;
  logic            open_bad;
  logic            prior_cut;
  logic [39:0]     recent_mass [MAX_MISSED];
  logic            recent_bad [MAX_MISSED];
  logic [JW-1:0]   recent_fill;
  logic [47:0]     protein_sum;
  logic            protein_bad;
  logic [31:0]     column_max [PROTEIN_COLUMNS];

  logic [24:0]     let_mass;
  logic            let_bad;
  logic            let_end;
  logic            let_cut;
  logic            close_then_add;
  logic [WW-1:0]   sum_acc;
  logic            bad_acc;
  logic [JW-1:0]   j;
  logic [28:0]     dv_rem;
  logic [20:0]     dv_d;
  logic [7:0]      dv_q;
  logic [2:0]      dv_k;
  logic            div_col;
  logic [RW-1:0]   mr;
  logic [AW-1:0]   sw;
  logic [CW-1:0]   rd_col;

  logic            mat_we;
  logic [AW-1:0]   mat_waddr, mat_raddr;
  logic [31:0]     mat_wdata, mat_rdata;
  logic            tal_we;
  logic [RW-1:0]   tal_waddr, tal_raddr;
  logic [31:0]     tal_wdata, tal_rdata;

  letter_t         lm;
  logic [8:0]      row9;
  logic [8:0]      col9;
  logic [RW-1:0]   row_c;
  logic [CW-1:0]   col_c;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   merge_addr;
  logic [3:0]      nmc4;
  logic [JW-1:0]   nmc;
  logic [JW-1:0]   jmax;
  logic [WW-1:0]   pep_val;
  logic [WW-1:0]   col_val;
  logic [37:0]     dv_prod;
  logic [7:0]      dv_est;
  logic [29:0]     dv_left;
  logic [31:0]     merged;
  logic [40:0]     open_sum;
  logic [48:0]     prot_sum;

  assign cfg_ready = 1'b1;
  assign lm        = letter_mass(residue);

  always_comb begin
    row9 = 9'(row);
    col9 = 9'(column);
    row_c = (row9 >= 9'(MASS_ROWS)) ? RW'(MASS_ROWS - 1) : RW'(row);
    col_c = (col9 >= 9'(PROTEIN_COLUMNS)) ? CW'(PROTEIN_COLUMNS - 1) : CW'(column);
    rd_addr = AW'(col_c) * AW'(MASS_ROWS) + AW'(row_c);
    merge_addr = AW'(CW'(dv_q)) * AW'(MASS_ROWS) + AW'(mr);
    nmc4 = (4'(missed_cleavages) > 4'(MAX_MISSED)) ? 4'(MAX_MISSED) : 4'(missed_cleavages);
    nmc = JW'(nmc4);
    jmax = (nmc < recent_fill) ? nmc : recent_fill;
    pep_val = bad_acc ? PROTON_MASS : sum_acc + WATER_MASS + PROTON_MASS;
    col_val = protein_bad ? '0 : WW'(protein_sum) + WATER_MASS;
    dv_prod = 38'(dv_rem) * 38'(div_col ? COL_RECIP : PEP_RECIP);
    dv_est = div_col ? 8'(dv_prod >> COL_RECIP_SHIFT) : 8'(dv_prod >> PEP_RECIP_SHIFT);
    dv_left = 30'(dv_rem) - 30'(dv_q) * 30'(dv_d);
    merged = sat_add32(mat_rdata, tal_rdata);
    open_sum = {1'b0, open_mass} + 41'(let_mass);
    prot_sum = {1'b0, protein_sum} + 49'(let_mass);
  end

  tpmh_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_matrix (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (mat_wdata),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  tpmh_ram #(.WIDTH(32), .DEPTH(MASS_ROWS)) u_tally (
    .clk   (clk),
    .we    (tal_we),
    .waddr (tal_waddr),
    .wdata (tal_wdata),
    .raddr (tal_raddr),
    .rdata (tal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    busy         = 1'b1;
    result_valid = 1'b0;
    cell_count   = mat_rdata;
    column_peak  = column_max[rd_col];
    mat_we       = 1'b0;
    mat_waddr    = sw;
    mat_wdata    = '0;
    mat_raddr    = rd_addr;
    tal_we       = 1'b0;
    tal_waddr    = RW'(sw);
    tal_wdata    = '0;
    tal_raddr    = RW'(dv_q);
    case (state)
      S_INIT: begin
        mat_we = 1'b1;
        tal_we = (32'(sw) < 32'(MASS_ROWS));
        if (32'(sw) == 32'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (req_type)
            REQ_RESIDUE: begin
              if (prior_cut && residue != CHAR_P) begin
                state_next = S_CLOSE;
              end else begin
                state_next = S_ADD;
              end
            end
            REQ_READ:  state_next = S_READ;
            REQ_CLEAR: state_next = S_CLEAR;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        result_valid = 1'b1;
        state_next   = S_IDLE;
      end
      S_CLEAR: begin
        mat_we = 1'b1;
        if (32'(sw) == 32'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_CLOSE: state_next = S_PEP_LOAD;
      S_PEP_LOAD: begin
        state_next = (pep_val >= PEP_LIMIT) ? S_TALLY_RD : S_DIV;
      end
      S_COL_LOAD: begin
        state_next = (col_val >= COL_LIMIT) ? S_MERGE_RD : S_DIV;
      end
      S_DIV: begin
        if (dv_k == 3'd0) begin
          state_next = div_col ? S_MERGE_RD : S_TALLY_RD;
        end
      end
      S_TALLY_RD: state_next = S_TALLY_WR;
      S_TALLY_WR: begin
        tal_we    = 1'b1;
        tal_waddr = RW'(dv_q);
        tal_wdata = sat_add32(tal_rdata, 32'd1);
        if (j < jmax) begin
          state_next = S_PEP_LOAD;
        end else begin
          state_next = close_then_add ? S_ADD : S_COL_LOAD;
        end
      end
      S_ADD: begin
        state_next = let_end ? S_CLOSE : S_IDLE;
      end
      S_MERGE_RD: begin
        mat_raddr  = merge_addr;
        tal_raddr  = mr;
        state_next = S_MERGE_WR;
      end
      S_MERGE_WR: begin
        mat_we    = 1'b1;
        mat_waddr = merge_addr;
        mat_wdata = merged;
        tal_we    = 1'b1;
        tal_waddr = mr;
        tal_wdata = '0;
        if (32'(mr) == 32'(MASS_ROWS - 1)) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_MERGE_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      missed_cleavages <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      missed_cleavages <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      open_mass   <= '0;
      open_bad    <= 1'b0;
      prior_cut   <= 1'b0;
      recent_fill <= '0;
      protein_sum <= '0;
      protein_bad <= 1'b0;
      sw          <= '0;
      for (int c = 0; c < PROTEIN_COLUMNS; c++) begin
        column_max[c] <= '0;
      end
    end else begin
      case (state)
        S_INIT, S_CLEAR: begin
          sw <= (32'(sw) == 32'(DEPTH - 1)) ? '0 : sw + AW'(1);
        end
        S_IDLE: begin
          if (start) begin
            let_mass <= lm.mass;
            let_bad  <= lm.bad;
            let_end  <= protein_end;
            let_cut  <= (residue == CHAR_K) || (residue == CHAR_R);
            rd_col   <= col_c;
            close_then_add <= 1'b1;
            sw       <= '0;
            if (req_type == REQ_CLEAR) begin
              for (int c = 0; c < PROTEIN_COLUMNS; c++) begin
                column_max[c] <= '0;
              end
            end
          end
        end
        S_CLOSE: begin
          sum_acc <= WW'(open_mass);
          bad_acc <= open_bad;
          j       <= '0;
        end
        S_PEP_LOAD: begin
          dv_rem  <= 29'(pep_val >> PEP_BIN_SHIFT);
          dv_d    <= PEP_BIN_ODD;
          dv_k    <= 3'd1;
          div_col <= 1'b0;
          dv_q    <= (pep_val >= PEP_LIMIT) ? 8'(MASS_ROWS - 1) : 8'd0;
        end
        S_COL_LOAD: begin
          dv_rem  <= 29'(col_val >> COL_BIN_SHIFT);
          dv_d    <= COL_BIN_ODD;
          dv_k    <= 3'd1;
          div_col <= 1'b1;
          mr      <= '0;
          dv_q    <= (col_val >= COL_LIMIT) ? 8'(PROTEIN_COLUMNS - 1) : 8'd0;
        end
        S_DIV: begin
          if (dv_k == 3'd1) begin
            dv_q <= dv_est;
          end else if (dv_left >= 30'(dv_d)) begin
            dv_q <= dv_q + 8'd1;
          end
          dv_k <= dv_k - 3'd1;
        end
        S_TALLY_WR: begin
          if (j < jmax) begin
            sum_acc <= sum_acc + WW'(recent_mass[RI'(j)]);
            bad_acc <= bad_acc | recent_bad[RI'(j)];
            j       <= j + JW'(1);
          end else begin
            for (int k = MAX_MISSED - 1; k > 0; k--) begin
              recent_mass[k] <= recent_mass[k - 1];
              recent_bad[k]  <= recent_bad[k - 1];
            end
            recent_mass[0] <= open_mass;
            recent_bad[0]  <= open_bad;
            if (32'(recent_fill) < 32'(MAX_MISSED)) begin
              recent_fill <= recent_fill + JW'(1);
            end
            open_mass <= '0;
            open_bad  <= 1'b0;
          end
        end
        S_ADD: begin
          open_mass   <= open_sum[40] ? MASS40_MAX : open_sum[39:0];
          open_bad    <= open_bad | let_bad;
          protein_sum <= prot_sum[48] ? MASS48_MAX : prot_sum[47:0];
          protein_bad <= protein_bad | let_bad;
          prior_cut   <= let_cut;
          close_then_add <= 1'b0;
        end
        S_MERGE_WR: begin
          if (merged > column_max[CW'(dv_q)]) begin
            column_max[CW'(dv_q)] <= merged;
          end
          mr <= mr + RW'(1);
          if (32'(mr) == 32'(MASS_ROWS - 1)) begin
            protein_sum <= '0;
            protein_bad <= 1'b0;
            prior_cut   <= 1'b0;
            recent_fill <= '0;
            open_mass   <= '0;
            open_bad    <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
